// ===== rtl/npb_pkg.sv =====
// Shared constants, types and the arctangent table for the nearest-point bearing unit.
`default_nettype none
package npb_pkg;
    localparam int COORD_W  = 24;                 // signed Q16.8 coordinate
    localparam int DIFF_W   = COORD_W + 1;        // signed coordinate difference
    localparam int SQ_W     = 2 * COORD_W + 1;    // one squared component
    localparam int DSQ_W    = SQ_W + 1;           // sum of three squares
    localparam int PREC     = 30 - COORD_W;
    localparam int RAD_W    = 62;                 // root unit operand
    localparam int ROOT_W   = RAD_W / 2;
    localparam int IDX_W    = 10;
    localparam int IDX_MAX  = 1023;
    localparam int DIST_W   = 25;
    localparam int OFS_W    = 18;
    localparam int YAW_W    = 19;
    localparam int PITCH_W  = 16;
    localparam int ANG_W    = 15;                 // 0..23040
    localparam int CX_W     = 54;                 // rotation datapath
    localparam int CZ_W     = 25;
    localparam int C_STEPS  = 23;
    localparam int CI_W     = 5;
    localparam int DEG90F   = 90 * 65536;
    localparam int DEG180   = 180 * 256;
    localparam int DEG360   = 360 * 256;
    localparam logic signed [OFS_W-1:0] OFS_RESET = -18'sd26880;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DRAIN, ST_SQ_D, ST_SQ_D_W, ST_SQ_H, ST_SQ_H_W,
        ST_AT_Y, ST_AT_Y_W, ST_AT_P, ST_AT_P_W, ST_EMIT
    } t_state;

    typedef enum logic [1:0] {CP_IDLE, CP_NORM, CP_ITER, CP_FIN} t_cor_phase;

    typedef struct packed {
        logic sq_start;
        logic sq_sel_h;
        logic at_start;
        logic at_sel_p;
        logic cap_dist;
        logic cap_h;
        logic cap_yaw;
        logic cap_pitch;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last_in_b;
        logic sq_done;
        logic at_done;
    } t_stat;

    // arctan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_tab(input logic [CI_W-1:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/npb_isqrt.sv =====
// Bit-pair serial integer square root with remainder, one root bit per cycle.
`default_nettype none
module npb_isqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [npb_pkg::RAD_W-1:0] i_rad,
    output logic                           o_done,
    output logic [npb_pkg::ROOT_W-1:0]     o_root,
    output logic [npb_pkg::RAD_W-1:0]      o_rem
);
    import npb_pkg::*;

    logic             r_busy, n_busy, r_done, n_done;
    logic [RAD_W-1:0] r_v, n_v, r_r, n_r, r_bit, n_bit;
    logic [RAD_W-1:0] trial;

    always_comb begin
        trial  = r_r + r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_v    = r_v;
        n_r    = r_r;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_v    = i_rad;
            n_r    = '0;
            n_bit  = {2'b01, {(RAD_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v = r_v - trial;
                n_r = (r_r >> 1) + r_bit;
            end else begin
                n_r = r_r >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_r   <= n_r;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];
    assign o_rem  = r_v;
endmodule
`default_nettype wire

// ===== rtl/npb_cordic.sv =====
// Vectoring rotation unit: rounded arctan(opp/adj) in 1/256 degree.
`default_nettype none
module npb_cordic (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [npb_pkg::ROOT_W-1:0] i_adj,
    input  wire logic [npb_pkg::ROOT_W-1:0] i_opp,
    output logic                            o_done,
    output logic [npb_pkg::ANG_W-1:0]       o_ang
);
    import npb_pkg::*;

    t_cor_phase              r_ph, n_ph;
    logic                    r_done, n_done;
    logic signed [CX_W-1:0]  r_x, n_x, r_y, n_y, xs, ys;
    logic signed [CZ_W-1:0]  r_z, n_z, zc;
    logic [CI_W-1:0]         r_i, n_i;
    logic [ANG_W-1:0]        r_ang, n_ang;
    logic [CX_W-1:0]         m;
    logic signed [CZ_W-1:0]  tab;

    always_comb begin
        m      = r_x | r_y;
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        tab    = CZ_W'(signed'({1'b0, atan_tab(r_i)}));
        zc     = r_z;
        n_ph   = r_ph;
        n_done = 1'b0;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_i    = r_i;
        n_ang  = r_ang;
        if (r_z < 0) zc = '0;
        else if (r_z > CZ_W'(DEG90F)) zc = CZ_W'(DEG90F);
        unique case (r_ph)
            CP_IDLE: begin
                if (i_start) begin
                    if ((i_adj | i_opp) == '0) begin
                        n_ang  = '0;
                        n_done = 1'b1;
                    end else begin
                        n_x  = CX_W'(i_adj);
                        n_y  = CX_W'(i_opp);
                        n_ph = CP_NORM;
                    end
                end
            end
            CP_NORM: begin
                // scale up until the larger leg reaches bit 50
                if (m < (CX_W'(1) << 42)) begin
                    n_x = r_x <<< 8;
                    n_y = r_y <<< 8;
                end else if (m < (CX_W'(1) << 50)) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                end else begin
                    n_z  = '0;
                    n_i  = '0;
                    n_ph = CP_ITER;
                end
            end
            CP_ITER: begin
                if (r_y >= 0) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + tab;
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - tab;
                end
                n_i = r_i + 1'b1;
                if (r_i == CI_W'(C_STEPS - 1)) n_ph = CP_FIN;
            end
            CP_FIN: begin
                n_ang  = ANG_W'((zc + CZ_W'(128)) >>> 8);
                n_done = 1'b1;
                n_ph   = CP_IDLE;
            end
            default: n_ph = CP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= CP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_i   <= n_i;
        r_ang <= n_ang;
    end

    assign o_done = r_done;
    assign o_ang  = r_ang;
endmodule
`default_nettype wire

// ===== rtl/npb_dp.sv =====
// Datapath: candidate pipeline, nearest-point registers, root and angle units, result registers.
`default_nettype none
module npb_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_acc,
    input  wire logic                              i_action,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_z,
    input  wire logic signed [31:0]                i_health,
    input  wire logic                              i_last,
    input  wire logic                              i_cfg_we,
    input  wire logic signed [npb_pkg::OFS_W-1:0]  i_cfg_data,
    input  wire npb_pkg::t_cmd                     i_cmd,
    output npb_pkg::t_stat                         o_stat,
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic [npb_pkg::IDX_W-1:0]              o_best_index,
    output logic [npb_pkg::DIST_W-1:0]             o_distance,
    output logic signed [npb_pkg::YAW_W-1:0]       o_yaw,
    output logic signed [npb_pkg::PITCH_W-1:0]     o_pitch
);
    import npb_pkg::*;

    logic signed [OFS_W-1:0]   r_ofs;
    logic signed [COORD_W-1:0] r_rx, r_ry, r_rz;
    // stage A
    logic                      r_a_vld, r_a_act, r_a_last, r_a_elig;
    logic signed [DIFF_W-1:0]  r_a_dx, r_a_dy, r_a_dz;
    // stage B
    logic                      r_b_vld, r_b_act, r_b_last, r_b_elig;
    logic signed [DIFF_W-1:0]  r_b_dx, r_b_dy, r_b_dz;
    logic [SQ_W-1:0]           r_b_sx, r_b_sy, r_b_sz;
    // kept candidate
    logic                      r_seen;
    logic [IDX_W-1:0]          r_cnt, r_pos;
    logic signed [DIFF_W-1:0]  r_bdx, r_bdy, r_bdz;
    logic [DSQ_W-1:0]          r_bdsq, r_bhsq;
    // final results
    logic [DIST_W-1:0]         r_dist;
    logic [ROOT_W-1:0]         r_h;
    logic [ANG_W-1:0]          r_t, r_a;
    logic                      r_valid, r_found;
    logic [IDX_W-1:0]          r_idx;
    logic [DIST_W-1:0]         r_odist;
    logic signed [YAW_W-1:0]   r_yaw;
    logic signed [PITCH_W-1:0] r_pitch;

    logic [DIFF_W-1:0]         mx, my, mz, ax, ay, az;
    logic [DSQ_W-1:0]          hsq, dsq;
    logic                      take;
    logic [RAD_W-1:0]          rad, rem;
    logic [ROOT_W-1:0]         root, c_adj, c_opp;
    logic                      sq_done, at_done;
    logic [ANG_W-1:0]          ang;
    logic signed [YAW_W:0]     t_res, yaw_sum;

    always_comb begin
        mx  = r_a_dx[DIFF_W-1] ? DIFF_W'(-r_a_dx) : DIFF_W'(r_a_dx);
        my  = r_a_dy[DIFF_W-1] ? DIFF_W'(-r_a_dy) : DIFF_W'(r_a_dy);
        mz  = r_a_dz[DIFF_W-1] ? DIFF_W'(-r_a_dz) : DIFF_W'(r_a_dz);
        ax  = r_bdx[DIFF_W-1] ? DIFF_W'(-r_bdx) : DIFF_W'(r_bdx);
        ay  = r_bdy[DIFF_W-1] ? DIFF_W'(-r_bdy) : DIFF_W'(r_bdy);
        az  = r_bdz[DIFF_W-1] ? DIFF_W'(-r_bdz) : DIFF_W'(r_bdz);
        hsq = DSQ_W'(r_b_sx) + DSQ_W'(r_b_sy);
        dsq = hsq + DSQ_W'(r_b_sz);
        take = r_b_elig && (!r_seen || dsq < r_bdsq);
        rad = i_cmd.sq_sel_h ? (RAD_W'(r_bhsq) << (2 * PREC)) : RAD_W'(r_bdsq);
        c_adj = i_cmd.at_sel_p ? r_h : ROOT_W'(ax);
        c_opp = i_cmd.at_sel_p ? (ROOT_W'(az) << PREC) : ROOT_W'(ay);
        // quadrant resolution of the bearing
        priority if (!r_bdx[DIFF_W-1] && !r_bdy[DIFF_W-1])
            t_res = (YAW_W+1)'(r_t);
        else if ((r_bdx <= 0) && !r_bdy[DIFF_W-1])
            t_res = (YAW_W+1)'(DEG180) - (YAW_W+1)'(r_t);
        else if ((r_bdx <= 0) && (r_bdy <= 0))
            t_res = (YAW_W+1)'(DEG180) + (YAW_W+1)'(r_t);
        else
            t_res = (YAW_W+1)'(DEG360) - (YAW_W+1)'(r_t);
        yaw_sum = t_res + (YAW_W+1)'(r_ofs);
    end

    npb_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_rad   (rad),
        .o_done  (sq_done),
        .o_root  (root),
        .o_rem   (rem)
    );

    npb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.at_start),
        .i_adj   (c_adj),
        .i_opp   (c_opp),
        .o_done  (at_done),
        .o_ang   (ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs   <= OFS_RESET;
            r_rx    <= '0;
            r_ry    <= '0;
            r_rz    <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_seen  <= 1'b0;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_bdx   <= '0;
            r_bdy   <= '0;
            r_bdz   <= '0;
            r_bdsq  <= '0;
            r_bhsq  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_ofs <= i_cfg_data;
            if (i_acc && !i_action) begin
                r_rx <= i_pos_x;
                r_ry <= i_pos_y;
                r_rz <= i_pos_z;
            end
            r_a_vld <= i_acc;
            r_b_vld <= r_a_vld;
            r_valid <= i_cmd.emit;
            if (i_cmd.emit || (r_b_vld && !r_b_act)) begin
                r_seen <= 1'b0;
                r_cnt  <= '0;
                r_pos  <= '0;
                r_bdx  <= '0;
                r_bdy  <= '0;
                r_bdz  <= '0;
                r_bdsq <= '0;
                r_bhsq <= '0;
            end else if (r_b_vld) begin
                if (r_cnt < IDX_W'(IDX_MAX)) r_cnt <= r_cnt + 1'b1;
                if (take) begin
                    r_seen <= 1'b1;
                    r_pos  <= r_cnt;
                    r_bdx  <= r_b_dx;
                    r_bdy  <= r_b_dy;
                    r_bdz  <= r_b_dz;
                    r_bdsq <= dsq;
                    r_bhsq <= hsq;
                end
            end
        end
        // payload, no reset
        r_a_act  <= i_action;
        r_a_last <= i_last;
        r_a_elig <= (i_health > 0);
        r_a_dx   <= DIFF_W'(i_pos_x) - DIFF_W'(r_rx);
        r_a_dy   <= DIFF_W'(i_pos_y) - DIFF_W'(r_ry);
        r_a_dz   <= DIFF_W'(i_pos_z) - DIFF_W'(r_rz);
        r_b_act  <= r_a_act;
        r_b_last <= r_a_last;
        r_b_elig <= r_a_elig;
        r_b_dx   <= r_a_dx;
        r_b_dy   <= r_a_dy;
        r_b_dz   <= r_a_dz;
        r_b_sx   <= SQ_W'(mx) * SQ_W'(mx);
        r_b_sy   <= SQ_W'(my) * SQ_W'(my);
        r_b_sz   <= SQ_W'(mz) * SQ_W'(mz);
        if (i_cmd.cap_dist && sq_done)
            r_dist <= root[DIST_W-1:0] + DIST_W'(rem > RAD_W'(root));
        if (i_cmd.cap_h && sq_done) r_h <= root;
        if (i_cmd.cap_yaw && at_done) r_t <= ang;
        if (i_cmd.cap_pitch && at_done) r_a <= ang;
        if (i_cmd.emit) begin
            r_found <= r_seen;
            r_idx   <= r_seen ? r_pos : '0;
            r_odist <= r_seen ? r_dist : '0;
            r_yaw   <= r_seen ? yaw_sum[YAW_W-1:0] : '0;
            if (!r_seen)
                r_pitch <= '0;
            else if (r_bdz > 0)
                r_pitch <= -PITCH_W'(r_a);
            else
                r_pitch <= PITCH_W'(r_a);
        end
    end

    assign o_stat.last_in_b = r_b_vld && r_b_act && r_b_last;
    assign o_stat.sq_done   = sq_done;
    assign o_stat.at_done   = at_done;
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_best_index = r_idx;
    assign o_distance   = r_odist;
    assign o_yaw        = r_yaw;
    assign o_pitch      = r_pitch;
endmodule
`default_nettype wire

// ===== rtl/npb_ctrl.sv =====
// Controller: drains the scan pipeline and sequences the root and angle work.
`default_nettype none
module npb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_acc_last,
    input  wire npb_pkg::t_stat i_stat,
    output npb_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import npb_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_acc_last) n_state = ST_DRAIN;
            ST_DRAIN:  if (i_stat.last_in_b) n_state = ST_SQ_D;
            ST_SQ_D:   n_state = ST_SQ_D_W;
            ST_SQ_D_W: if (i_stat.sq_done) n_state = ST_SQ_H;
            ST_SQ_H:   n_state = ST_SQ_H_W;
            ST_SQ_H_W: if (i_stat.sq_done) n_state = ST_AT_Y;
            ST_AT_Y:   n_state = ST_AT_Y_W;
            ST_AT_Y_W: if (i_stat.at_done) n_state = ST_AT_P;
            ST_AT_P:   n_state = ST_AT_P_W;
            ST_AT_P_W: if (i_stat.at_done) n_state = ST_EMIT;
            ST_EMIT:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_SQ_D:   o_cmd.sq_start = 1'b1;
            ST_SQ_D_W: o_cmd.cap_dist = 1'b1;
            ST_SQ_H: begin
                o_cmd.sq_start = 1'b1;
                o_cmd.sq_sel_h = 1'b1;
            end
            ST_SQ_H_W: begin
                o_cmd.sq_sel_h = 1'b1;
                o_cmd.cap_h    = 1'b1;
            end
            ST_AT_Y:   o_cmd.at_start = 1'b1;
            ST_AT_Y_W: o_cmd.cap_yaw  = 1'b1;
            ST_AT_P: begin
                o_cmd.at_start = 1'b1;
                o_cmd.at_sel_p = 1'b1;
            end
            ST_AT_P_W: begin
                o_cmd.at_sel_p  = 1'b1;
                o_cmd.cap_pitch = 1'b1;
            end
            ST_EMIT:   o_cmd.emit = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/nearest_point_bearing.sv =====
// Top level of the nearest-point bearing unit.
// Candidates and reference beats are taken one per cycle, while busy is low, through a 3-stage
// compare pipeline. A last candidate holds busy while the controller drains the pipeline,
// runs two bit-serial roots and two rotation runs (normalize plus 23 steps each) and emits;
// the result strobe shows in the first cycle with busy low again.
// Reset (synchronous, active low) clears the scan, the reference point and the yaw offset
// (back to -26880); the result has no back-pressure and shows for one cycle.
`default_nettype none
module nearest_point_bearing (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_action,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_z,
    input  wire logic signed [31:0]                 i_health,
    input  wire logic                               i_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic signed [npb_pkg::OFS_W-1:0]   i_cfg_data,
    output logic                                    o_valid,
    output logic                                    o_found,
    output logic [npb_pkg::IDX_W-1:0]               o_best_index,
    output logic [npb_pkg::DIST_W-1:0]              o_distance,
    output logic signed [npb_pkg::YAW_W-1:0]        o_yaw,
    output logic signed [npb_pkg::PITCH_W-1:0]      o_pitch
);
    import npb_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  acc;

    assign acc         = start && !busy;
    assign o_cfg_ready = 1'b1;

    npb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc_last (acc && i_action && i_last),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    npb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_action     (i_action),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_health     (i_health),
        .i_last       (i_last),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_best_index (o_best_index),
        .o_distance   (o_distance),
        .o_yaw        (o_yaw),
        .o_pitch      (o_pitch)
    );
endmodule
`default_nettype wire

// ===== rtl/npb_checker.sv =====
// Port-level checks for the nearest-point bearing unit, bound to the top level.
`default_nettype none
module npb_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        i_action,
    input wire logic        i_last,
    input wire logic        o_valid,
    input wire logic        o_found,
    input wire logic [9:0]  o_best_index,
    input wire logic [24:0] o_distance
);
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action && i_last) |=> busy)
        else $error("last candidate did not raise busy");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_best_index == 10'd0 && o_distance == 25'd0))
        else $error("empty scan gave nonzero result");

    a_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy)) else $error("result without prior busy");
endmodule

bind nearest_point_bearing npb_props u_npb_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .i_last       (i_last),
    .o_valid      (o_valid),
    .o_found      (o_found),
    .o_best_index (o_best_index),
    .o_distance   (o_distance)
);
`default_nettype wire

// ===== tb/npb_checker.sv =====
// Checker for the nearest-point bearing unit: watches beats, predicts results, compares.
`default_nettype none
module npb_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic                               i_busy,
    input  wire logic                               i_action,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic signed [npb_pkg::COORD_W-1:0] i_pos_z,
    input  wire logic signed [31:0]                 i_health,
    input  wire logic                               i_last,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic signed [npb_pkg::OFS_W-1:0]   i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic                               i_found,
    input  wire logic [npb_pkg::IDX_W-1:0]          i_best_index,
    input  wire logic [npb_pkg::DIST_W-1:0]         i_distance,
    input  wire logic signed [npb_pkg::YAW_W-1:0]   i_yaw,
    input  wire logic signed [npb_pkg::PITCH_W-1:0] i_pitch,
    output int                                      o_pending,
    output int                                      o_errors
);
    import npb_pkg::*;

    typedef struct {
        logic                       found;
        logic [IDX_W-1:0]           index;
        logic [DIST_W-1:0]          dlen;
        logic signed [YAW_W-1:0]    yaw;
        logic signed [PITCH_W-1:0]  pitch;
    } t_bearing;

    localparam longint ARCTAN_FINE [C_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    t_bearing bearing_q[$];

    longint          ref_x, ref_y, ref_z;
    longint          near_dx, near_dy, near_dz;
    longint unsigned near_dsq;
    int              near_pos, scan_pos;
    bit              any_seen;
    longint          yaw_ofs;

    assign o_pending = bearing_q.size();

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round(atan(opp/adj)) in 1/256 degree
    function automatic longint arctan_deg(longint unsigned adj, longint unsigned opp);
        longint x, y, z, xs, ys;
        if ((adj | opp) == 0) return 0;
        while ((adj | opp) < (64'd1 << 50)) begin
            adj = adj << 1;
            opp = opp << 1;
        end
        x = adj;
        y = opp;
        z = 0;
        for (int i = 0; i < C_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ARCTAN_FINE[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARCTAN_FINE[i];
            end
        end
        if (z < 0) z = 0;
        if (z > DEG90F) z = DEG90F;
        return (z + 128) >>> 8;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_bearing predict_bearing();
        t_bearing        b;
        longint unsigned r, ax, ay, az, h;
        longint          t, yw, pt;
        b = '{found: 1'b0, index: '0, dlen: '0, yaw: '0, pitch: '0};
        if (!any_seen) return b;
        r = root_floor(near_dsq);
        if (near_dsq - r * r > r) r++;
        ax = magn(near_dx);
        ay = magn(near_dy);
        az = magn(near_dz);
        if (ax == 0 && ay == 0) begin
            t = 0;
        end else begin
            t = arctan_deg(ax, ay);
            if (near_dx >= 0 && near_dy >= 0) t = t;
            else if (near_dx <= 0 && near_dy >= 0) t = DEG180 - t;
            else if (near_dx <= 0 && near_dy <= 0) t = DEG180 + t;
            else t = DEG360 - t;
        end
        yw = t + yaw_ofs;
        pt = 0;
        if (near_dsq != 0) begin
            h  = root_floor((ax * ax + ay * ay) << (2 * PREC));
            pt = arctan_deg(h, az << PREC);
            if (near_dz > 0) pt = -pt;
        end
        b.found = 1'b1;
        b.index = near_pos[IDX_W-1:0];
        b.dlen  = r[DIST_W-1:0];
        b.yaw   = yw[YAW_W-1:0];
        b.pitch = pt[PITCH_W-1:0];
        return b;
    endfunction

    task automatic clear_scan();
        any_seen = 0;
        scan_pos = 0;
        near_dx  = 0;
        near_dy  = 0;
        near_dz  = 0;
        near_dsq = 0;
        near_pos = 0;
    endtask

    always @(posedge i_clk) begin
        longint          dx, dy, dz;
        longint unsigned dsq;
        t_bearing        got, want;
        if (!i_rst_n) begin
            ref_x = 0; ref_y = 0; ref_z = 0;
            clear_scan();
            yaw_ofs = OFS_RESET;
            bearing_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) yaw_ofs = i_cfg_data;
            if (i_start && !i_busy) begin
                if (!i_action) begin
                    ref_x = i_pos_x; ref_y = i_pos_y; ref_z = i_pos_z;
                    clear_scan();
                end else begin
                    dx  = longint'(i_pos_x) - ref_x;
                    dy  = longint'(i_pos_y) - ref_y;
                    dz  = longint'(i_pos_z) - ref_z;
                    dsq = dx * dx + dy * dy + dz * dz;
                    if (i_health > 0 && (!any_seen || dsq < near_dsq)) begin
                        any_seen = 1;
                        near_dx = dx; near_dy = dy; near_dz = dz;
                        near_dsq = dsq;
                        near_pos = scan_pos;
                    end
                    if (scan_pos < IDX_MAX) scan_pos++;
                    if (i_last) begin
                        bearing_q = {bearing_q, predict_bearing()};
                        clear_scan();
                    end
                end
            end
            if (i_valid) begin
                got = '{found: i_found, index: i_best_index, dlen: i_distance,
                        yaw: i_yaw, pitch: i_pitch};
                if (bearing_q.size() == 0) begin
                    $display("%0t: unexpected result beat, exp none, got found=%0d idx=%0d dist=%0d",
                             $time, got.found, got.index, got.dlen);
                    o_errors <= o_errors + 1;
                end else begin
                    want = bearing_q.pop_front();
                    if (got.found !== want.found || got.index !== want.index ||
                        got.dlen !== want.dlen || got.yaw !== want.yaw ||
                        got.pitch !== want.pitch) begin
                        $display("%0t: mismatch exp found=%0d idx=%0d dist=%0d yaw=%0d pitch=%0d",
                                 $time, want.found, want.index, want.dlen, want.yaw, want.pitch);
                        $display("%0t:          got found=%0d idx=%0d dist=%0d yaw=%0d pitch=%0d",
                                 $time, got.found, got.index, got.dlen, got.yaw, got.pitch);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Stimulus and verdict for the nearest-point bearing unit.
`default_nettype none
module tb;
    import npb_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 250;

    logic                       i_clk, i_rst_n, start, busy;
    logic                       i_action, i_last;
    logic signed [COORD_W-1:0]  i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0]         i_health;
    logic                       i_cfg_valid, o_cfg_ready;
    logic signed [OFS_W-1:0]    i_cfg_data;
    logic                       o_valid, o_found;
    logic [IDX_W-1:0]           o_best_index;
    logic [DIST_W-1:0]          o_distance;
    logic signed [YAW_W-1:0]    o_yaw;
    logic signed [PITCH_W-1:0]  o_pitch;
    int                         pending, errors, cycles, sent;
    logic signed [COORD_W-1:0]  cur_x, cur_y, cur_z;

    nearest_point_bearing u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_health(i_health), .i_last(i_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_found(o_found), .o_best_index(o_best_index),
        .o_distance(o_distance), .o_yaw(o_yaw), .o_pitch(o_pitch)
    );

    npb_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_action(i_action), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_health(i_health), .i_last(i_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_found(o_found), .i_best_index(o_best_index),
        .i_distance(o_distance), .i_yaw(o_yaw), .i_pitch(o_pitch),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // one beat; random gap before it except in the quiet stretch
    task automatic send_beat(logic act, logic signed [COORD_W-1:0] x, y, z,
                             logic signed [31:0] hp, logic lst);
        bit quiet;
        quiet = sent > 400 && sent < 700;
        if (!quiet && $urandom_range(0, 99) < 23) begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1;
        i_action <= act; i_pos_x <= x; i_pos_y <= y; i_pos_z <= z;
        i_health <= hp; i_last <= lst;
        do @(posedge i_clk); while (busy);
        sent++;
        if (!act) begin
            cur_x = x; cur_y = y; cur_z = z;
        end
    endtask

    task automatic settle();
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_offset(logic signed [OFS_W-1:0] v);
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] c);
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(COORD_W-1){1'b0}}};
            1:       return {1'b0, {(COORD_W-1){1'b1}}};
            2, 3, 4: return c + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
            5, 6:    return c + COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_health();
        case ($urandom_range(0, 7))
            0:       return 32'($urandom_range(0, 4)) - 32'sd2;
            1:       return 32'h7fffffff;
            2:       return 32'h80000000;
            3:       return 32'($urandom);
            default: return 32'($urandom_range(1, 1000));
        endcase
    endfunction

    task automatic random_scan(int len);
        logic signed [COORD_W-1:0] px, py, pz;
        logic signed [31:0]        hp;
        px = 0; py = 0; pz = 0;
        if ($urandom_range(0, 3) != 0)
            send_beat(0, pick_coord(cur_x), pick_coord(cur_y), pick_coord(cur_z),
                      32'($urandom), 1'($urandom));
        for (int k = 0; k < len; k++) begin
            // a repeat of the previous point makes a distance tie
            if (k == 0 || $urandom_range(0, 9) != 0) begin
                px = pick_coord(cur_x); py = pick_coord(cur_y); pz = pick_coord(cur_z);
            end
            hp = pick_health();
            send_beat(1, px, py, pz, hp, k == len - 1);
        end
    endtask

    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};

    initial begin
        int phase;
        cycles = 0; sent = 0;
        cur_x = 0; cur_y = 0; cur_z = 0;
        i_rst_n = 0; start = 0; i_action = 0; i_last = 0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0; i_health = 0;
        i_cfg_valid = 0; i_cfg_data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty scan, extremes, quadrants, zero cases, ties
        send_beat(1, 100, 200, 300, 0, 1);
        send_beat(1, 5, 5, 5, 32'h80000000, 0);
        send_beat(1, 5, 5, 5, -1, 1);
        send_beat(0, CMIN, CMIN, CMIN, 32'h7fffffff, 1);
        send_beat(1, CMAX, CMAX, CMAX, 32'h7fffffff, 1);
        send_beat(0, 0, 0, 0, 0, 0);
        send_beat(1, 0, 0, 0, 1, 1);
        send_beat(1, 0, 0, 777, 1, 1);
        send_beat(1, 0, 0, -777, 5, 1);
        send_beat(1, -300, 0, 10, 1, 1);
        send_beat(1, -300, -400, 0, 1, 1);
        send_beat(1, 0, -400, 0, 1, 1);
        send_beat(1, 300, -400, -50, 1, 1);
        send_beat(1, 300, 400, 50, 1, 1);
        send_beat(1, 0, 400, 0, 1, 1);
        send_beat(1, 10, 10, 10, 3, 0);
        send_beat(1, -10, 10, -10, 3, 0);
        send_beat(1, 20, 0, 0, 3, 1);
        send_beat(1, CMAX, CMIN, CMAX, 9, 0);
        send_beat(1, 50, 60, 70, -5, 0);
        send_beat(1, 1, 2, 3, 8, 1);
        settle();

        // offset settings, extremes first; each phase is a batch of random scans, phase 2 one long scan
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       write_offset(-18'sd92160);
                1:       write_offset(18'sd92160);
                2:       write_offset(18'sd0);
                3:       write_offset(18'sh1ffff);
                5:       write_offset(OFS_RESET);
                default: write_offset(OFS_W'($urandom));
            endcase
            if (phase == 2) begin
                // long scan drives the index into saturation
                random_scan(1030);
            end else begin
                for (int s = 0; s < 23; s++) random_scan($urandom_range(1, 8));
            end
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
